// ===== hw/rtl/phc_pkg.sv =====
// Shared types and constants of the pixel hit clusterer.
// Used by phc_front, phc_engine and the top level; depends on nothing.
package phc_pkg;

  localparam int MAX_OPEN_CLUSTERS_DEF = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  SPACE_PAD_RESET = 8'd5;
  localparam logic [15:0] TIME_PAD_RESET = 16'd20;
  localparam logic [31:0] CLOSE_TIMEOUT_RESET = 32'd50000;

  localparam logic [1:0] REG_SPACE_PAD = 2'd0;
  localparam logic [1:0] REG_TIME_PAD = 2'd1;
  localparam logic [1:0] REG_CLOSE_TIMEOUT = 2'd2;

  localparam logic CMD_HIT = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] KIND_TIMEOUT = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  hit_x;
    logic [7:0]  hit_y;
    logic [37:0] hit_time;
    logic [9:0]  hit_weight;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mean_x;
    logic [7:0]  mean_y;
    logic [37:0] mean_time;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic        flush;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [37:0] t;
    logic [9:0]  w;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  typedef struct packed {
    logic [31:0]        sum_x;
    logic [31:0]        sum_y;
    logic [63:0]        sum_t;
    logic [31:0]        weight;
    logic [7:0]         seed_x;
    logic [7:0]         seed_y;
    logic [37:0]        seed_t;
    logic signed [9:0]  x_lo;
    logic signed [9:0]  x_hi;
    logic signed [9:0]  y_lo;
    logic signed [9:0]  y_hi;
    logic signed [39:0] t_lo;
    logic signed [39:0] t_hi;
  } slot_t;

endpackage

// ===== hw/rtl/phc_front.sv =====
// Front end of the clusterer: takes commands and queues them classified.
// Depends on phc_pkg.
module phc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  phc_pkg::item_t      item,
  input  logic                pop,
  output phc_pkg::queue_out_t q
);

  localparam int Depth = phc_pkg::QUEUE_DEPTH;
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  phc_pkg::entry_t  store [Depth];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    fill;
  logic             push;
  logic             take;
  phc_pkg::entry_t  in_entry;

  assign busy = (fill == CW'(Depth));
  assign push = start && !busy;
  assign take = pop && (fill != '0);

  always_comb begin
    in_entry.flush = (item.command == phc_pkg::CMD_FLUSH);
    in_entry.x = item.hit_x;
    in_entry.y = item.hit_y;
    in_entry.t = item.hit_time;
    in_entry.w = item.hit_weight;
  end

  assign q.valid = (fill != '0);
  assign q.entry = store[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(Depth - 1)) ? '0 : wp + PW'(1);
      end
      if (take) begin
        rp <= (rp == PW'(Depth - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !take) begin
        fill <= fill + CW'(1);
      end else if (take && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wp] <= in_entry;
    end
  end

endmodule

// ===== hw/rtl/phc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Self-contained; used by phc_engine for the weighted means.
module phc_divider #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CNW = $clog2(NW + 1);

  logic [CNW-1:0] cnt;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  d;
  logic [DW:0]    shifted;
  logic [DW+1:0]  diff;

  assign shifted = {rem, quo[NW-1]};
  assign diff = {1'b0, shifted} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNW'(NW);
    end else if (busy) begin
      cnt <= cnt - CNW'(1);
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      d <= den;
    end else if (busy) begin
      if (!diff[DW+1]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/phc_engine.sv =====
// Back end of the clusterer: the slot table memory and the sequencer that
// scans, merges, sweeps and flushes it. Depends on phc_pkg and phc_divider.
module phc_engine #(
  parameter int MAX_CLUSTERS = phc_pkg::MAX_OPEN_CLUSTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  phc_pkg::queue_out_t q,
  output logic                pop,
  input  logic [7:0]          space_pad,
  input  logic [15:0]         time_pad,
  input  logic [31:0]         close_timeout,
  output logic                strobe,
  output phc_pkg::result_t    result
);

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int CW = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SC_RD  = 14'b00000000000010,
    S_SC_CHK = 14'b00000000000100,
    S_SC_CP  = 14'b00000000001000,
    S_SC_END = 14'b00000000010000,
    S_SW_RD  = 14'b00000000100000,
    S_SW_CHK = 14'b00000001000000,
    S_SW_DIV = 14'b00000010000000,
    S_SW_CP  = 14'b00000100000000,
    S_SW_END = 14'b00001000000000,
    S_FL_RD  = 14'b00010000000000,
    S_FL_CHK = 14'b00100000000000,
    S_FL_DIV = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_t;

  function automatic phc_pkg::slot_t combine(phc_pkg::slot_t a, phc_pkg::slot_t b);
    phc_pkg::slot_t r;
    begin
      r = a;
      r.sum_x = a.sum_x + b.sum_x;
      r.sum_y = a.sum_y + b.sum_y;
      r.sum_t = a.sum_t + b.sum_t;
      r.weight = a.weight + b.weight;
      if ($signed(b.x_lo) < $signed(a.x_lo)) r.x_lo = b.x_lo;
      if ($signed(b.x_hi) > $signed(a.x_hi)) r.x_hi = b.x_hi;
      if ($signed(b.y_lo) < $signed(a.y_lo)) r.y_lo = b.y_lo;
      if ($signed(b.y_hi) > $signed(a.y_hi)) r.y_hi = b.y_hi;
      if ($signed(b.t_lo) < $signed(a.t_lo)) r.t_lo = b.t_lo;
      if ($signed(b.t_hi) > $signed(a.t_hi)) r.t_hi = b.t_hi;
      return r;
    end
  endfunction

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   i;
  logic [CW-1:0]   j;
  logic [AW-1:0]   first;
  logic            first_valid;
  logic            full_pend;
  phc_pkg::entry_t hit;
  logic [17:0]     prod_x;
  logic [17:0]     prod_y;
  logic [47:0]     prod_t;
  phc_pkg::slot_t  acc;
  phc_pkg::slot_t  em;
  logic [1:0]      em_kind;
  phc_pkg::result_t pend;
  phc_pkg::result_t fin_res;
  logic            pend_valid;

  phc_pkg::slot_t  mem [MAX_CLUSTERS];
  phc_pkg::slot_t  rdata;
  logic            we;
  logic [AW-1:0]   wa;
  logic [AW-1:0]   ra;
  phc_pkg::slot_t  wd;

  phc_pkg::slot_t  hit_rec;
  phc_pkg::slot_t  upd;
  phc_pkg::slot_t  merged;
  logic            holds;
  logic            expired;
  logic [CW-1:0]   nc;
  logic [CW-1:0]   jm1;
  logic            room;

  logic            div_start;
  logic            busy_x;
  logic            busy_y;
  logic            busy_t;
  logic            div_busy;
  logic [63:0]     quo_x;
  logic [63:0]     quo_y;
  logic [63:0]     quo_t;

  logic            prod_valid;
  phc_pkg::result_t prod_res;
  phc_pkg::result_t div_res;

  logic signed [9:0]  hx;
  logic signed [9:0]  hy;
  logic signed [9:0]  pad10;
  logic signed [39:0] ht;
  logic signed [39:0] tp;

  assign hx = $signed({2'b00, hit.x});
  assign hy = $signed({2'b00, hit.y});
  assign pad10 = $signed({2'b00, space_pad});
  assign ht = $signed({2'b00, hit.t});
  assign tp = $signed({24'd0, time_pad});

  always_comb begin
    hit_rec.sum_x = {14'd0, prod_x};
    hit_rec.sum_y = {14'd0, prod_y};
    hit_rec.sum_t = {16'd0, prod_t};
    hit_rec.weight = {22'd0, hit.w};
    hit_rec.seed_x = hit.x;
    hit_rec.seed_y = hit.y;
    hit_rec.seed_t = hit.t;
    hit_rec.x_lo = hx - pad10;
    hit_rec.x_hi = hx + pad10;
    hit_rec.y_lo = hy - pad10;
    hit_rec.y_hi = hy + pad10;
    hit_rec.t_lo = ht - tp;
    hit_rec.t_hi = ht + tp;
  end

  assign holds = ($signed(rdata.x_lo) <= hx) && ($signed(rdata.x_hi) >= hx) &&
                 ($signed(rdata.y_lo) <= hy) && ($signed(rdata.y_hi) >= hy) &&
                 ($signed(rdata.t_lo) <= ht) && ($signed(rdata.t_hi) >= ht);
  assign expired = $signed({3'b000, hit.t}) >
                   ($signed({rdata.t_hi[39], rdata.t_hi}) + $signed({9'd0, close_timeout}));
  assign upd = combine(rdata, hit_rec);
  assign merged = combine(acc, upd);
  assign nc = count - CW'(1);
  assign jm1 = j - CW'(1);
  assign room = (count < CW'(MAX_CLUSTERS));
  assign pop = (state == S_IDLE) && q.valid;

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    ra = '0;
    unique case (state)
      S_SC_RD: ra = i[AW-1:0];
      S_SC_CHK: ra = nc[AW-1:0];
      S_SC_CP: begin
        we = 1'b1;
        wa = i[AW-1:0];
      end
      S_SC_END: begin
        if (first_valid) begin
          we = 1'b1;
          wa = first;
          wd = acc;
        end else if (room) begin
          we = 1'b1;
          wa = count[AW-1:0];
          wd = hit_rec;
        end
      end
      S_SW_RD: ra = jm1[AW-1:0];
      S_SW_DIV: ra = nc[AW-1:0];
      S_SW_CP: begin
        we = 1'b1;
        wa = jm1[AW-1:0];
      end
      S_SW_END: begin
        if (full_pend && room) begin
          we = 1'b1;
          wa = count[AW-1:0];
          wd = hit_rec;
        end
      end
      S_FL_RD: ra = i[AW-1:0];
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  assign div_start = ((state == S_SW_CHK) && expired) || (state == S_FL_CHK);
  assign div_busy = busy_x || busy_y || busy_t;

  phc_divider #(.NW(64), .DW(32)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num({32'd0, rdata.sum_x}),
    .den(rdata.weight), .busy(busy_x), .quo(quo_x)
  );
  phc_divider #(.NW(64), .DW(32)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num({32'd0, rdata.sum_y}),
    .den(rdata.weight), .busy(busy_y), .quo(quo_y)
  );
  phc_divider #(.NW(64), .DW(32)) u_div_t (
    .clk(clk), .rst(rst), .start(div_start), .num(rdata.sum_t),
    .den(rdata.weight), .busy(busy_t), .quo(quo_t)
  );

  always_comb begin
    div_res.kind = em_kind;
    div_res.last_of_run = 1'b0;
    if (em.weight == 32'd0) begin
      div_res.mean_x = em.seed_x;
      div_res.mean_y = em.seed_y;
      div_res.mean_time = em.seed_t;
    end else begin
      div_res.mean_x = quo_x[7:0];
      div_res.mean_y = quo_y[7:0];
      div_res.mean_time = quo_t[37:0];
    end
  end

  always_comb begin
    prod_valid = 1'b0;
    prod_res = div_res;
    if (((state == S_SW_DIV) || (state == S_FL_DIV)) && !div_busy) begin
      prod_valid = 1'b1;
    end else if ((state == S_SW_END) && full_pend && !room) begin
      prod_valid = 1'b1;
      prod_res.kind = phc_pkg::KIND_DROP;
      prod_res.mean_x = hit.x;
      prod_res.mean_y = hit.y;
      prod_res.mean_time = hit.t;
    end
  end

  always_comb begin
    fin_res = pend;
    fin_res.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      i <= '0;
      j <= '0;
      first_valid <= 1'b0;
      full_pend <= 1'b0;
      pend_valid <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= pend_valid && (prod_valid || (state == S_FINISH));
      if (prod_valid) begin
        if (pend_valid) begin
          result <= pend;
        end
        pend <= prod_res;
        pend_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (q.valid) begin
            hit <= q.entry;
            prod_x <= q.entry.x * q.entry.w;
            prod_y <= q.entry.y * q.entry.w;
            prod_t <= q.entry.t * q.entry.w;
            i <= '0;
            first_valid <= 1'b0;
            state <= q.entry.flush ? S_FL_RD : S_SC_RD;
          end
        end
        S_SC_RD: begin
          state <= (i >= count) ? S_SC_END : S_SC_CHK;
        end
        S_SC_CHK: begin
          if (!holds) begin
            i <= i + CW'(1);
            state <= S_SC_RD;
          end else if (!first_valid) begin
            acc <= upd;
            first <= i[AW-1:0];
            first_valid <= 1'b1;
            i <= i + CW'(1);
            state <= S_SC_RD;
          end else begin
            acc <= merged;
            count <= nc;
            state <= (i != nc) ? S_SC_CP : S_SC_RD;
          end
        end
        S_SC_CP: begin
          state <= S_SC_RD;
        end
        S_SC_END: begin
          full_pend <= 1'b0;
          if (first_valid) begin
            j <= count;
          end else if (room) begin
            count <= count + CW'(1);
            j <= count + CW'(1);
          end else begin
            full_pend <= 1'b1;
            j <= count;
          end
          state <= S_SW_RD;
        end
        S_SW_RD: begin
          state <= (j == '0) ? S_SW_END : S_SW_CHK;
        end
        S_SW_CHK: begin
          em <= rdata;
          em_kind <= phc_pkg::KIND_TIMEOUT;
          if (expired) begin
            state <= S_SW_DIV;
          end else begin
            j <= jm1;
            state <= S_SW_RD;
          end
        end
        S_SW_DIV: begin
          if (!div_busy) begin
            count <= nc;
            if (jm1 != nc) begin
              state <= S_SW_CP;
            end else begin
              j <= jm1;
              state <= S_SW_RD;
            end
          end
        end
        S_SW_CP: begin
          j <= jm1;
          state <= S_SW_RD;
        end
        S_SW_END: begin
          if (full_pend && room) begin
            count <= count + CW'(1);
          end
          state <= S_FINISH;
        end
        S_FL_RD: begin
          if (i >= count) begin
            count <= '0;
            state <= S_FINISH;
          end else begin
            state <= S_FL_CHK;
          end
        end
        S_FL_CHK: begin
          em <= rdata;
          em_kind <= phc_pkg::KIND_FLUSH;
          state <= S_FL_DIV;
        end
        S_FL_DIV: begin
          if (!div_busy) begin
            i <= i + CW'(1);
            state <= S_FL_RD;
          end
        end
        S_FINISH: begin
          if (pend_valid) begin
            result <= fin_res;
            pend_valid <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pixel_hit_clusterer_core.sv =====
// Top level of the pixel hit clusterer: configuration registers, command
// queue and table engine. Depends on phc_pkg, phc_front and phc_engine.
//
// Results leave on result with a one-cycle strobe and cannot be held off,
// so the receiver must take one whenever strobe is high. Each result is
// delayed until the next one of the same transaction is known, so that
// last_of_run marks the final one. A command is taken when start is high
// and busy is low; a two-entry queue lets commands arrive while the engine
// works. A hit runs a match scan over the open clusters, merging away each
// further cluster that holds it, then a timeout sweep; each emitted cluster
// waits on the 64-step serial divider that forms the means. A flush runs
// that divider once for each open cluster. There is no clearing pass after
// reset.
module pixel_hit_clusterer_core #(
  parameter int MAX_OPEN_CLUSTERS = phc_pkg::MAX_OPEN_CLUSTERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  phc_pkg::item_t   item,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [31:0]      wr_data,
  output logic             strobe,
  output phc_pkg::result_t result
);

  logic [7:0]          space_pad;
  logic [15:0]         time_pad;
  logic [31:0]         close_timeout;
  logic                pop;
  phc_pkg::queue_out_t q;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pad <= phc_pkg::SPACE_PAD_RESET;
      time_pad <= phc_pkg::TIME_PAD_RESET;
      close_timeout <= phc_pkg::CLOSE_TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        phc_pkg::REG_SPACE_PAD: space_pad <= wr_data[7:0];
        phc_pkg::REG_TIME_PAD: time_pad <= wr_data[15:0];
        phc_pkg::REG_CLOSE_TIMEOUT: close_timeout <= wr_data;
        default: ;
      endcase
    end
  end

  phc_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .pop(pop), .q(q)
  );

  phc_engine #(.MAX_CLUSTERS(MAX_OPEN_CLUSTERS)) u_engine (
    .clk(clk), .rst(rst), .q(q), .pop(pop), .space_pad(space_pad),
    .time_pad(time_pad), .close_timeout(close_timeout), .strobe(strobe),
    .result(result)
  );

endmodule
